/* hw/rtl/skc_pkg.sv */
package skc_pkg;

  // Fixed-point format of every field: Q16.16 in 32-bit words.
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;

  // Square root datapath.
  localparam int unsigned SqW   = 2 * DataW;
  localparam int unsigned RootW = DataW;

  // Normalized distance R inside the support (R <= 2.0) needs 18 bits.
  localparam int unsigned RW   = 18;
  localparam int unsigned FacW = 19;
  localparam int unsigned NumW = 34;
  localparam int unsigned DenW = 19;
  localparam int unsigned QuoW = 18;

  localparam logic [RW-1:0]  QOne       = 18'd65536;
  localparam logic [RW-1:0]  QTwo       = 18'd131072;
  localparam logic [19:0]    QFour      = 20'd262144;
  localparam logic [16:0]    TwoThirds  = 17'd43690;
  // floor(x / 6) == (x * RecipSix) >> 18 for every x below 2^17.
  localparam logic [16:0]    RecipSix   = 17'd43691;
  localparam logic [63:0]    ClampCap   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FuncKernel = 2'd0,
    FuncGrad   = 2'd1,
    FuncLap    = 2'd2,
    FuncNone   = 2'd3
  } skc_func_e;

  typedef enum logic [1:0] {
    RegSmooth    = 2'd0,
    RegInvSmooth = 2'd1,
    RegScale     = 2'd2
  } skc_reg_e;

  // Per-item data that rides along with the square root pipeline.
  typedef struct packed {
    skc_func_e         func;
    logic [DataW-1:0]  ax;
    logic [DataW-1:0]  ay;
    logic              nx;
    logic              ny;
  } skc_vec_t;

  // Per-item data that rides along with the divider pipeline.
  typedef struct packed {
    skc_vec_t          vec;
    logic              support;
    logic              need_div;
    logic              neg;
    logic [FacW-1:0]   fac;
  } skc_dside_t;

  // alpha / h^2, clamped, with its clamp flag.
  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } skc_coef_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             sat;
  } skc_enc_t;

endpackage

/* hw/rtl/sph_cubic_spline_kernel_2d.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   func_i, offset_x_i, offset_y_i
// out       output     out_valid_o / out_ready_i scalar_value_o, grad_x_o, grad_y_o,
//                                                within_support_o, saturated_o
// cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One transfer is taken per cycle while no stall holds; items pass the front stages,
// the 32-stage square root, the 18-stage divider, scaling and the output register.
// Reset clears all valid bits and loads 1/h = 1.0 and alpha = 31296.
// A stall holds every stage only when a finished result waits and the last stage is
// full, so bubbles still drain and no item is lost or repeated.
module sph_cubic_spline_kernel_2d import skc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic signed [DataW-1:0] offset_x_i,
  input  logic signed [DataW-1:0] offset_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] scalar_value_o,
  output logic signed [DataW-1:0] grad_x_o,
  output logic signed [DataW-1:0] grad_y_o,
  output logic                    within_support_o,
  output logic                    saturated_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [DataW-1:0]        cfg_data_i
);

  // Saturate a magnitude with a sign into a 32-bit two's complement field.
  function automatic skc_enc_t enc_sat(input logic [79:0] mag, input logic neg);
    skc_enc_t   res;
    logic [79:0] lim;
    logic [31:0] m;
    lim       = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
    res.sat   = mag > lim;
    m         = res.sat ? lim[31:0] : mag[31:0];
    res.value = neg ? (32'd0 - m) : m;
    return res;
  endfunction

  logic             en;
  logic [DataW-1:0] alpha, inv;
  skc_coef_t        coef;

  skc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .alpha_o    (alpha),
    .inv_o      (inv),
    .coef_o     (coef)
  );

  // ---------------------------------------------------------------------------
  // Front: magnitudes and signs of the offset, then the squared distance.
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] ox, oy;
  logic             va_q, vb_q, vc_q;
  skc_vec_t         vec_a_q, vec_b_q, vec_c_q;
  logic [SqW-1:0]   sqx_q, sqy_q, sum_q;

  assign ox = offset_x_i;
  assign oy = offset_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_a_q.func <= skc_func_e'(func_i);
      vec_a_q.nx   <= ox[DataW-1];
      vec_a_q.ny   <= oy[DataW-1];
      vec_a_q.ax   <= ox[DataW-1] ? (32'd0 - ox) : ox;
      vec_a_q.ay   <= oy[DataW-1] ? (32'd0 - oy) : oy;
      vec_b_q      <= vec_a_q;
      sqx_q        <= SqW'(vec_a_q.ax) * SqW'(vec_a_q.ax);
      sqy_q        <= SqW'(vec_a_q.ay) * SqW'(vec_a_q.ay);
      vec_c_q      <= vec_b_q;
      sum_q        <= sqx_q + sqy_q;
    end
  end

  // |d| = floor(sqrt(dx^2 + dy^2)), exact on the Q32.32 square.
  logic             vs;
  logic [RootW-1:0] root;
  skc_vec_t         vec_s;

  skc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vc_q),
    .radicand_i (sum_q),
    .side_i     (vec_c_q),
    .valid_o    (vs),
    .root_o     (root),
    .side_o     (vec_s)
  );

  // ---------------------------------------------------------------------------
  // R = |d| / h, support test, and the polynomial pieces of R.
  // ---------------------------------------------------------------------------
  logic             vd_q, ve_q, vf_q, vg_q;
  skc_vec_t         vec_d_q, vec_e_q, vec_f_q, vec_g_q;
  logic [63:0]      prod_d_q;
  logic [47:0]      r48;
  logic [RW-1:0]    rr_e_q, rr_f_q, rr_g_q;
  logic             within_e_q, within_f_q, within_g_q;
  logic             le1_e_q, le1_f_q, le1_g_q;
  logic [RW-1:0]    t_e, sq_in;
  logic [19:0]      u_e;
  logic [32:0]      sqv_f_q;
  logic [16:0]      t_f_q;
  logic [18:0]      u_f_q;
  logic [16:0]      a_f, b_f;
  logic [33:0]      cube_p;
  logic [35:0]      tu_p;
  logic [16:0]      cube_g_q, r2_g_q;
  logic [NumW-1:0]  tu_g_q;
  logic [31:0]      tt_g_q;

  assign r48   = prod_d_q[63:FracBits];
  assign t_e   = QTwo - rr_e_q;
  assign u_e   = 20'({rr_e_q, 1'b0}) + 20'(rr_e_q) - 20'(QTwo);
  assign sq_in = le1_e_q ? rr_e_q : t_e;

  assign a_f    = sqv_f_q[32:16];
  assign b_f    = le1_f_q ? rr_f_q[16:0] : t_f_q;
  assign cube_p = 34'(a_f) * 34'(b_f);
  assign tu_p   = 36'(t_f_q) * 36'(u_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en) begin
      vd_q <= vs;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_d_q    <= vec_s;
      prod_d_q   <= 64'(root) * 64'(inv);

      vec_e_q    <= vec_d_q;
      rr_e_q     <= r48[RW-1:0];
      within_e_q <= r48 <= 48'(QTwo);
      le1_e_q    <= r48 <= 48'(QOne);

      vec_f_q    <= vec_e_q;
      rr_f_q     <= rr_e_q;
      within_f_q <= within_e_q;
      le1_f_q    <= le1_e_q;
      sqv_f_q    <= 33'(36'(sq_in) * 36'(sq_in));
      t_f_q      <= t_e[16:0];
      u_f_q      <= u_e[18:0];

      vec_g_q    <= vec_f_q;
      rr_g_q     <= rr_f_q;
      within_g_q <= within_f_q;
      le1_g_q    <= le1_f_q;
      cube_g_q   <= cube_p[32:16];
      r2_g_q     <= a_f;
      tt_g_q     <= sqv_f_q[31:0];
      tu_g_q     <= tu_p[NumW-1:0];
    end
  end

  // Factor per function. Outside R <= 1 the gradient and the Laplacian need
  // a division by 2R, which goes through the divider; otherwise the factor
  // is formed here and the quotient is ignored.
  skc_dside_t       dside;
  logic [NumW-1:0]  num;
  logic [DenW-1:0]  den;
  logic [18:0]      poly, three_r;
  logic [33:0]      six_p;
  logic [20:0]      nine_r;
  logic [19:0]      k9;

  assign three_r = 19'({rr_g_q, 1'b0}) + 19'(rr_g_q);
  assign nine_r  = 21'({rr_g_q, 3'b000}) + 21'(rr_g_q);
  assign k9      = nine_r[20:1];
  assign six_p   = 34'(cube_g_q) * 34'(RecipSix);
  assign poly    = 19'(TwoThirds) + 19'(cube_g_q[16:1]) - 19'(r2_g_q);
  assign den     = {rr_g_q, 1'b0};

  always_comb begin
    dside.vec      = vec_g_q;
    dside.support  = within_g_q;
    dside.need_div = 1'b0;
    dside.neg      = 1'b0;
    dside.fac      = '0;
    num            = '0;
    case (vec_g_q.func)
      FuncKernel: begin
        dside.fac = le1_g_q ? poly : 19'(six_p[33:18]);
      end
      FuncGrad: begin
        if (le1_g_q) begin
          dside.fac = 19'(QTwo) - 19'(three_r[18:1]);
        end else begin
          dside.need_div = 1'b1;
          num            = NumW'(tt_g_q);
        end
      end
      FuncLap: begin
        if (le1_g_q) begin
          dside.neg = k9 < QFour;
          dside.fac = dside.neg ? 19'(QFour - k9) : 19'(k9 - QFour);
        end else begin
          dside.need_div = 1'b1;
          num            = tu_g_q;
        end
      end
      default: begin
      end
    endcase
  end

  logic            vq;
  logic [QuoW-1:0] quo;
  skc_dside_t      dside_q;

  skc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg_q),
    .num_i   (num),
    .den_i   (den),
    .side_i  (dside),
    .valid_o (vq),
    .quo_o   (quo),
    .side_o  (dside_q)
  );

  // ---------------------------------------------------------------------------
  // Scaling: m = (A * factor) >> 16 with A = alpha for the kernel value and
  // alpha/h^2 otherwise, clamped to 2^63-1. For the gradient m is then applied
  // to both offset components.
  // ---------------------------------------------------------------------------
  logic [FacW-1:0] facf;
  logic [63:0]     amul;
  logic            vh_q, vi_q, vj_q;
  skc_dside_t      side_h_q, side_i_q, side_j_q;
  logic            asat_h_q, sat_i_q, sat_j_q;
  logic [50:0]     plo_h_q, phi_h_q;
  logic [82:0]     mfull;
  logic [66:0]     msh;
  logic            msat;
  logic [63:0]     m_i_q, m_j_q;
  logic [63:0]     klx_q, khx_q, kly_q, khy_q;

  assign facf  = dside_q.need_div ? FacW'(quo) : dside_q.fac;
  assign amul  = (dside_q.vec.func == FuncKernel) ? 64'(alpha) : coef.value;
  assign mfull = 83'(plo_h_q) + {phi_h_q, 32'd0};
  assign msh   = mfull[82:FracBits];
  assign msat  = |msh[66:63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else if (en) begin
      vh_q <= vq;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_h_q <= dside_q;
      asat_h_q <= coef.sat && (dside_q.vec.func != FuncKernel);
      plo_h_q  <= 51'(amul[31:0]) * 51'(facf);
      phi_h_q  <= 51'(amul[63:32]) * 51'(facf);

      side_i_q <= side_h_q;
      sat_i_q  <= asat_h_q | msat;
      m_i_q    <= msat ? ClampCap : msh[63:0];

      side_j_q <= side_i_q;
      sat_j_q  <= sat_i_q;
      m_j_q    <= m_i_q;
      klx_q    <= 64'(m_i_q[31:0]) * 64'(side_i_q.vec.ax);
      khx_q    <= 64'(m_i_q[63:32]) * 64'(side_i_q.vec.ax);
      kly_q    <= 64'(m_i_q[31:0]) * 64'(side_i_q.vec.ay);
      khy_q    <= 64'(m_i_q[63:32]) * 64'(side_i_q.vec.ay);
    end
  end

  // ---------------------------------------------------------------------------
  // Final encoding and the output register.
  // ---------------------------------------------------------------------------
  logic [95:0]      gxf, gyf;
  skc_enc_t         es, ex, ey;
  logic [DataW-1:0] scalar_d, gx_d, gy_d;
  logic             sat_d;
  logic             out_valid_q;
  logic [DataW-1:0] scalar_q, gx_q, gy_q;
  logic             within_q, sat_q;

  assign gxf = 96'(klx_q) + {khx_q, 32'd0};
  assign gyf = 96'(kly_q) + {khy_q, 32'd0};
  assign es  = enc_sat(80'(m_j_q), side_j_q.neg);
  assign ex  = enc_sat(gxf[95:FracBits], !side_j_q.vec.nx);
  assign ey  = enc_sat(gyf[95:FracBits], !side_j_q.vec.ny);

  always_comb begin
    scalar_d = '0;
    gx_d     = '0;
    gy_d     = '0;
    sat_d    = 1'b0;
    if (side_j_q.support) begin
      case (side_j_q.vec.func)
        FuncKernel, FuncLap: begin
          scalar_d = es.value;
          sat_d    = sat_j_q | es.sat;
        end
        FuncGrad: begin
          gx_d  = ex.value;
          gy_d  = ey.value;
          sat_d = sat_j_q | ex.sat | ey.sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the pipeline only when the output register is full, not being
  // taken, and the last stage has an item to move into it.
  assign en         = !(out_valid_q && !out_ready_i && vj_q);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vj_q || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vj_q) begin
      scalar_q <= scalar_d;
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      within_q <= side_j_q.support;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scalar_value_o   = scalar_q;
  assign grad_x_o         = gx_q;
  assign grad_y_o         = gy_q;
  assign within_support_o = within_q;
  assign saturated_o      = sat_q;

endmodule

/* hw/rtl/skc_cfg.sv */
module skc_cfg import skc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i,
  output logic [DataW-1:0] alpha_o,
  output logic [DataW-1:0] inv_o,
  output skc_coef_t        coef_o
);

  logic [DataW-1:0] alpha_q, inv_q;
  logic [63:0]      p1_q;
  logic [63:0]      plo_q;
  logic [47:0]      phi_q;
  logic [47:0]      m1;
  logic [79:0]      full;
  logic [63:0]      sh;
  skc_coef_t        coef_q;

  // The smoothing length itself is not stored here; its writes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= 32'd65536;
      alpha_q <= 32'd31296;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSmooth: begin
        end
        RegInvSmooth: begin
          inv_q <= cfg_data_i;
        end
        RegScale: begin
          alpha_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // alpha * (1/h) * (1/h), each product truncated, via p1_q, plo_q/phi_q and coef_q.
  assign m1   = p1_q[63:FracBits];
  assign full = 80'(plo_q) + {phi_q, 32'd0};
  assign sh   = full[79:FracBits];

  always_ff @(posedge clk_i) begin
    p1_q         <= 64'(alpha_q) * 64'(inv_q);
    plo_q        <= 64'(m1[31:0]) * 64'(inv_q);
    phi_q        <= 48'(m1[47:32]) * 48'(inv_q);
    coef_q.sat   <= sh[63];
    coef_q.value <= sh[63] ? ClampCap : sh;
  end

  assign alpha_o = alpha_q;
  assign inv_o   = inv_q;
  assign coef_o  = coef_q;

endmodule

/* hw/rtl/skc_sqrt.sv */
module skc_sqrt import skc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SqW-1:0]   radicand_i,
  input  skc_vec_t         side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output skc_vec_t         side_o
);

  localparam int unsigned RemW = RootW + 3;

  logic [RootW-1:0] valid_q, valid_d;
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RemW-1:0]  rem_d  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RootW-1:0] root_d [RootW];
  logic [SqW-1:0]   rad_q  [RootW];
  logic [SqW-1:0]   rad_d  [RootW];
  skc_vec_t         side_q [RootW];
  skc_vec_t         side_d [RootW];

  // One result bit per stage, restoring digit recurrence.
  always_comb begin
    logic [RemW-1:0]  rem_in, rsh, trial;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   rad_in;
    logic             ge;
    for (int k = 0; k < RootW; k++) begin
      if (k == 0) begin
        rem_in     = '0;
        root_in    = '0;
        rad_in     = radicand_i;
        valid_d[k] = valid_i;
        side_d[k]  = side_i;
      end else begin
        rem_in     = rem_q[k-1];
        root_in    = root_q[k-1];
        rad_in     = rad_q[k-1];
        valid_d[k] = valid_q[k-1];
        side_d[k]  = side_q[k-1];
      end
      rsh       = {rem_in[RemW-3:0], rad_in[SqW-1:SqW-2]};
      trial     = {1'b0, root_in, 2'b01};
      ge        = rsh >= trial;
      rem_d[k]  = ge ? (rsh - trial) : rsh;
      root_d[k] = {root_in[RootW-2:0], ge};
      rad_d[k]  = {rad_in[SqW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

/* hw/rtl/skc_div.sv */
module skc_div import skc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  skc_dside_t      side_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quo_o,
  output skc_dside_t      side_o
);

  localparam int unsigned RemW = DenW + QuoW - 1;

  logic [QuoW-1:0] valid_q, valid_d;
  logic [RemW-1:0] rem_q  [QuoW];
  logic [RemW-1:0] rem_d  [QuoW];
  logic [DenW-1:0] den_q  [QuoW];
  logic [DenW-1:0] den_d  [QuoW];
  logic [QuoW-1:0] quo_q  [QuoW];
  logic [QuoW-1:0] quo_d  [QuoW];
  skc_dside_t      side_q [QuoW];
  skc_dside_t      side_d [QuoW];

  // Restoring division, most significant quotient bit first, one bit per stage.
  always_comb begin
    logic [RemW-1:0] rem_in, dsh;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            ge;
    for (int k = 0; k < QuoW; k++) begin
      if (k == 0) begin
        rem_in     = RemW'(num_i);
        den_in     = den_i;
        quo_in     = '0;
        valid_d[k] = valid_i;
        side_d[k]  = side_i;
      end else begin
        rem_in     = rem_q[k-1];
        den_in     = den_q[k-1];
        quo_in     = quo_q[k-1];
        valid_d[k] = valid_q[k-1];
        side_d[k]  = side_q[k-1];
      end
      dsh      = RemW'(den_in) << (QuoW - 1 - k);
      ge       = rem_in >= dsh;
      rem_d[k] = ge ? (rem_in - dsh) : rem_in;
      quo_d[k] = {quo_in[QuoW-2:0], ge};
      den_d[k] = den_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  import skc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result item of the kernel unit, as seen on the output port.
  typedef struct {
    logic [DataW-1:0] scalar;
    logic [DataW-1:0] gx;
    logic [DataW-1:0] gy;
    logic             support;
    logic             sat;
  } kernel_out_t;

  // Holds the register copy, computes the expected result of every accepted
  // offset and compares the results in transfer order.
  class kernel_scoreboard;
    logic [31:0] smooth_len;
    logic [31:0] inv_smooth;
    logic [31:0] alpha;
    kernel_out_t pending[$];
    int unsigned errors;

    function new();
      smooth_len = 32'h0001_0000;
      inv_smooth = 32'h0001_0000;
      alpha      = 32'd31296;
      errors     = 0;
    endfunction

    function void set_reg(skc_reg_e idx, logic [31:0] value);
      case (idx)
        RegSmooth:    smooth_len = value;
        RegInvSmooth: inv_smooth = value;
        RegScale:     alpha      = value;
        default: ;
      endcase
    endfunction

    // Q16.16 product of two magnitudes, clamped to the 63-bit cap.
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, inout bit sat);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> FracBits;
      if (prod > {64'd0, ClampCap}) begin
        sat = 1'b1;
        return ClampCap;
      end
      return prod[63:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    // Puts a sign on a magnitude and clamps it into a 32-bit field.
    function automatic logic [31:0] to_field(logic [63:0] mag, bit neg, inout bit sat);
      if (!neg) begin
        if (mag > 64'h7FFF_FFFF) begin
          mag = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'd0 - mag[31:0];
    endfunction

    function automatic kernel_out_t predict(skc_func_e f, logic [31:0] ox, logic [31:0] oy);
      kernel_out_t res;
      logic [63:0] ax, ay, dmag, r, poly, t, a_h2, fac, k, g, k9, u, r2, r3;
      bit nx, ny, sat, neg;
      nx = ox[31];
      ny = oy[31];
      ax = {32'd0, nx ? 32'd0 - ox : ox};
      ay = {32'd0, ny ? 32'd0 - oy : oy};
      sat = 1'b0;
      res.scalar = 0;
      res.gx = 0;
      res.gy = 0;
      dmag = root64(ax * ax + ay * ay);
      r = qmul(dmag, {32'd0, inv_smooth}, sat);
      res.support = (r <= 64'h2_0000);
      if (!res.support || f == FuncNone) begin
        sat = 1'b0;
      end else if (f == FuncKernel) begin
        if (r <= 64'h1_0000) begin
          r2 = (r * r) >> FracBits;
          r3 = (r2 * r) >> FracBits;
          poly = (64'h2_0000 / 3) + (r3 >> 1) - r2;
        end else begin
          t = 64'h2_0000 - r;
          poly = ((((t * t) >> FracBits) * t) >> FracBits) / 6;
        end
        res.scalar = to_field(qmul({32'd0, alpha}, poly, sat), 1'b0, sat);
      end else begin
        a_h2 = qmul(qmul({32'd0, alpha}, {32'd0, inv_smooth}, sat), {32'd0, inv_smooth}, sat);
        if (f == FuncGrad) begin
          if (r <= 64'h1_0000) begin
            fac = 64'h2_0000 - ((3 * r) >> 1);
          end else begin
            t = 64'h2_0000 - r;
            fac = (t * t) / (2 * r);
          end
          k = qmul(a_h2, fac, sat);
          res.gx = to_field(qmul(k, ax, sat), !nx, sat);
          res.gy = to_field(qmul(k, ay, sat), !ny, sat);
        end else begin
          if (r <= 64'h1_0000) begin
            k9 = (9 * r) >> 1;
            neg = k9 < 64'h4_0000;
            g = neg ? 64'h4_0000 - k9 : k9 - 64'h4_0000;
          end else begin
            t = 64'h2_0000 - r;
            u = 3 * r - 64'h2_0000;
            neg = 1'b0;
            g = (t * u) / (2 * r);
          end
          res.scalar = to_field(qmul(a_h2, g, sat), neg, sat);
        end
      end
      res.sat = sat;
      return res;
    endfunction

    function void note_input(skc_func_e f, logic [31:0] ox, logic [31:0] oy);
      pending.push_back(predict(f, ox, oy));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(kernel_out_t got);
      kernel_out_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.scalar, 0);
        return;
      end
      want = pending.pop_front();
      if (got.scalar !== want.scalar) report("scalar_value", got.scalar, want.scalar);
      if (got.gx !== want.gx) report("grad_x", got.gx, want.gx);
      if (got.gy !== want.gy) report("grad_y", got.gy, want.gy);
      if (got.support !== want.support) report("within_support", got.support, want.support);
      if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
    endtask
  endclass

  localparam int unsigned CycleLimit = 300000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              func_i = '0;
  logic signed [DataW-1:0] offset_x_i = '0;
  logic signed [DataW-1:0] offset_y_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] scalar_value_o;
  logic signed [DataW-1:0] grad_x_o;
  logic signed [DataW-1:0] grad_y_o;
  logic                    within_support_o;
  logic                    saturated_o;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_idx_i = '0;
  logic [DataW-1:0]        cfg_data_i = '0;

  kernel_scoreboard kernel_sb = new();
  int unsigned      cycle_count = 0;
  int unsigned      burst_left = 0;

  sph_cubic_spline_kernel_2d dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The watchdog ends a hung run; the limit leaves a wide margin over the
  // slowest legal run with every gap and stall at its longest.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both monitors sample at the rising edge, where each transfer happens.
  always @(posedge clk_i) begin
    kernel_out_t seen;
    if (rst_ni && in_valid_i && in_ready_o) begin
      kernel_sb.note_input(skc_func_e'(func_i), offset_x_i, offset_y_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.scalar  = scalar_value_o;
      seen.gx      = grad_x_o;
      seen.gy      = grad_y_o;
      seen.support = within_support_o;
      seen.sat     = saturated_o;
      kernel_sb.check_result(seen);
    end
  end

  // The receiver changes its habit in turn: always ready, a coin flip each
  // cycle, a fixed duty-cycle stall, or a random ready three times in four.
  // This moves the stalls across every stage of the pipeline.
  always @(negedge clk_i) begin
    case ((cycle_count / 64) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (cycle_count % 7) >= 3;
      default: out_ready_i <= $urandom_range(0, 3) != 0;
    endcase
  end

  // Presents one item and holds it until the transfer. Within a burst valid
  // stays high, so the next item follows back to back; a burst ends in a gap.
  task automatic send_item(skc_func_e f, logic [31:0] ox, logic [31:0] oy);
    in_valid_i = 1'b1;
    func_i     = f;
    offset_x_i = ox;
    offset_y_i = oy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Stops sending until every outstanding result has been checked.
  task automatic drain();
    in_valid_i = 1'b0;
    while (kernel_sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(skc_reg_e idx, logic [31:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    kernel_sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random offsets mostly fall within three smoothing lengths so that both
  // spline segments and the outside are all reached; the rest use the full
  // 32-bit range so every offset bit toggles.
  task automatic send_random(int unsigned count);
    logic [63:0] reach;
    logic [31:0] ox, oy;
    skc_func_e   f;
    reach = (64'd3 << 32) / kernel_sb.inv_smooth;
    if (reach > 64'h7FFF_FFFF) reach = 64'h7FFF_FFFF;
    repeat (count) begin
      f = ($urandom_range(0, 9) == 0) ? FuncNone : skc_func_e'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) begin
        ox = $urandom;
        oy = $urandom;
      end else begin
        ox = $urandom_range(0, reach[31:0]);
        oy = $urandom_range(0, reach[31:0]);
        if ($urandom_range(0, 1)) ox = 32'd0 - ox;
        if ($urandom_range(0, 1)) oy = 32'd0 - oy;
      end
      send_item(f, ox, oy);
    end
  endtask

  initial begin
    logic [31:0] phase_h[5]   = '{32'h0000_8000, 32'h0004_0000, 32'hFFFF_FFFF,
                                  32'h0000_0001, 32'h0001_0000};
    logic [31:0] phase_inv[5] = '{32'h0002_0000, 32'h0000_4000, 32'h0000_0001,
                                  32'hFFFF_FFFF, 32'h0001_0000};
    logic [31:0] phase_a[5]   = '{32'd125184, 32'd1956, 32'd0,
                                  32'hFFFF_FFFF, 32'd31296};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    burst_left = $urandom_range(1, 20);

    // Directed items under the reset settings: zero distance for every
    // selector, the segment joint at R = 1, the support edge at R = 2 and
    // just past it, the unused selector, and the offset extremes.
    send_item(FuncKernel, 32'd0, 32'd0);
    send_item(FuncGrad,   32'd0, 32'd0);
    send_item(FuncLap,    32'd0, 32'd0);
    send_item(FuncNone,   32'd0, 32'd0);
    send_item(FuncNone,   32'h0000_8000, 32'd0);
    send_item(FuncKernel, 32'h0001_0000, 32'd0);
    send_item(FuncGrad,   32'h0001_0000, 32'd0);
    send_item(FuncLap,    32'd0, 32'hFFFF_0000);
    send_item(FuncKernel, 32'h0002_0000, 32'd0);
    send_item(FuncGrad,   32'd0, 32'hFFFE_0000);
    send_item(FuncLap,    32'h0002_0000, 32'd0);
    send_item(FuncKernel, 32'h0002_0001, 32'd0);
    send_item(FuncGrad,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(FuncLap,    32'h8000_0000, 32'h8000_0000);
    send_item(FuncKernel, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(FuncGrad,   32'h0000_8000, 32'hFFFF_4CCD);
    send_item(FuncLap,    32'hFFFE_8000, 32'h0001_0000);
    send_item(FuncGrad,   32'h0000_0001, 32'hFFFF_FFFF);
    send_item(FuncLap,    32'h0000_C000, 32'h0000_C000);
    send_random(70);

    // Each further phase waits for an idle pipeline before new settings,
    // from half and four times the unit length to the register extremes.
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(RegSmooth, phase_h[p]);
      write_reg(RegInvSmooth, phase_inv[p]);
      write_reg(RegScale, phase_a[p]);
      send_random(p == 3 ? 50 : 65);
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (kernel_sb.errors == 0 && kernel_sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/skc_pkg.sv
hw/rtl/skc_cfg.sv
hw/rtl/skc_sqrt.sv
hw/rtl/skc_div.sv
hw/rtl/sph_cubic_spline_kernel_2d.sv
tb/tb_top.sv
